/* rtl/square_window_sum_core_defines.svh */
// assertion macros shared by the square window sum rtl
`ifndef SQUARE_WINDOW_SUM_CORE_DEFINES_SVH
`define SQUARE_WINDOW_SUM_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising aclk edge out of reset
`define SWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising aclk edge out of reset
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sws_pkg.sv */
// types and constants of the square window sum block
`default_nettype none

package sws_pkg;

    localparam int SUM_BITS = 28;
    localparam int POS_BITS = 6;
    localparam int CFG_BITS = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int OUT_BITS = SUM_BITS + 2 * POS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MATRIX_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = 1'b1;

    localparam logic [CFG_BITS-1:0] MATRIX_SIZE_RESET = 7'd64;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

    // per-beat position flags carried from the address stage to the sum stage
    typedef struct packed {
        logic                row_zero;
        logic                row_ge_k;
        logic                row_full;
        logic                col_zero;
        logic                col_ge_k;
        logic                col_full;
        logic                col_last;
        logic                row_last;
        logic [POS_BITS-1:0] top_row;
        logic [POS_BITS-1:0] left_col;
    } sws_ctrl_t;

endpackage

`default_nettype wire

/* rtl/square_window_sum_core.sv */
// top level of the square window sum block: box sums over a streamed square matrix
//
// usage
//   s_ channel: one matrix element per beat, row-major, s_tdata holds the element
//   m_ channel: one beat per complete window, m_tdata holds the window sum and its
//     top-left row and column, m_tuser flags the last window of a row, m_tlast the
//     last window of the matrix
//   cfg port: cfg_we writes cfg_wdata into register cfg_index (0 matrix size,
//     1 window size) at the clock edge; any write restarts the matrix at row 0
//   throughput: one element per cycle while no stall holds, set by the single
//     write and read port pair of the element store and the column strip ram
//   path to m_tvalid: the rams read on the accepting edge, then the sum stage
//     loads the output register that drives m_tvalid
//   stall: while m_tvalid is high and m_tready low, s_tready drops and the
//     pipeline holds; a result waiting in the output register does not block
//     the next beat once it is taken
//   reset: synchronous active-low aresetn clears positions and valid bits and
//     restores matrix size 64 and window size 3; no clearing pass is needed,
//     the strip sums of row 0 start from zero by position
//   a window larger than the matrix gives no results; elements still count
`default_nettype none
`include "square_window_sum_core_defines.svh"

module square_window_sum_core #(
    parameter int MAX_SIZE  = 64,
    parameter int DATA_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // config write port
    input  wire logic                                  cfg_we,
    input  wire logic [sws_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [sws_pkg::CFG_BITS-1:0]          cfg_wdata,
    // element stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata: element_value from bit 0
    input  wire logic [((DATA_BITS+7)/8)*8-1:0]        s_tdata,
    // window stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata: window_sum, top_row, left_column from bit 0
    output logic [sws_pkg::OUT_TDATA_BITS-1:0]         m_tdata,
    // m_tuser: row_end
    output logic                                       m_tuser,
    // matrix_end
    output logic                                       m_tlast
);

    import sws_pkg::*;

    localparam int IDX_BITS    = $clog2(MAX_SIZE);
    localparam int CMP_BITS    = (IDX_BITS + 2 > 8) ? IDX_BITS + 2 : 8;
    localparam int STRIP_BITS  = DATA_BITS + IDX_BITS;
    localparam int STORE_DEPTH = 1 << (2 * IDX_BITS);

    // configuration
    logic [CFG_BITS-1:0] matrix_size_reg, matrix_size_next;
    logic [CFG_BITS-1:0] window_size_reg, window_size_next;

    // raster position of the next element
    logic [IDX_BITS-1:0] row_reg, row_next;
    logic [IDX_BITS-1:0] col_reg, col_next;

    // sum stage registers
    logic                      v1_reg, v1_next;
    sws_ctrl_t                 ctrl1_reg;
    logic [IDX_BITS-1:0]       col1_reg;
    logic signed [DATA_BITS-1:0] elem1_reg;
    logic signed [STRIP_BITS-1:0] last_strip_reg, last_strip_next;
    logic signed [SUM_BITS-1:0]   row_sum_reg, row_sum_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic [OUT_TDATA_BITS-1:0] m_data_reg;
    logic                      m_user_reg;
    logic                      m_last_reg;

    // effective sizes, widened for compares
    logic [CMP_BITS-1:0] n_eff;
    logic [CMP_BITS-1:0] k_ext;
    logic [CMP_BITS-1:0] r_ext;
    logic [CMP_BITS-1:0] c_ext;
    logic                k_valid;
    logic                k_one;

    logic      adv;
    logic      s_accept;
    logic      s1_fire;
    sws_ctrl_t ctrl0;

    // element store ports
    logic [2*IDX_BITS-1:0]  store_wr_addr;
    logic [2*IDX_BITS-1:0]  store_rd_addr;
    logic [DATA_BITS-1:0]   store_rd_data;

    // column strip ram, two copies for two read addresses
    logic                  strip_we;
    logic [IDX_BITS-1:0]   strip_wr_addr;
    logic [IDX_BITS-1:0]   strip_rd_a_addr;
    logic [IDX_BITS-1:0]   strip_rd_b_addr;
    logic [STRIP_BITS-1:0] strip_rd_a_data;
    logic [STRIP_BITS-1:0] strip_rd_b_data;

    // sum stage arithmetic
    logic signed [STRIP_BITS-1:0] old_strip;
    logic signed [STRIP_BITS-1:0] drop_elem;
    logic signed [STRIP_BITS-1:0] strip_new;
    logic signed [STRIP_BITS-1:0] far_strip;
    logic signed [SUM_BITS-1:0]   row_base;
    logic signed [SUM_BITS-1:0]   row_drop;
    logic                         produce;

    // ---------------------------------------------------------------
    // sizes: matrix size zero counts as one, above MAX_SIZE it saturates
    // ---------------------------------------------------------------
    always_comb begin
        k_ext = CMP_BITS'(window_size_reg);
        if (matrix_size_reg == '0) begin
            n_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(matrix_size_reg) > CMP_BITS'(MAX_SIZE)) begin
            n_eff = CMP_BITS'(MAX_SIZE);
        end else begin
            n_eff = CMP_BITS'(matrix_size_reg);
        end
        k_valid = (k_ext != '0) && (k_ext <= n_eff);
        k_one   = (k_ext == CMP_BITS'(1));
        r_ext   = CMP_BITS'(row_reg);
        c_ext   = CMP_BITS'(col_reg);
    end

    // handshake: the whole pipe moves when the output slot is free
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;
    assign s1_fire  = v1_reg && adv;

    // ---------------------------------------------------------------
    // address stage: position flags and ram reads for the accepted beat
    // ---------------------------------------------------------------
    always_comb begin
        ctrl0.row_zero = (row_reg == '0);
        ctrl0.row_ge_k = (r_ext >= k_ext);
        ctrl0.row_full = (r_ext + CMP_BITS'(1) >= k_ext);
        ctrl0.col_zero = (col_reg == '0);
        ctrl0.col_ge_k = (c_ext >= k_ext);
        ctrl0.col_full = (c_ext + CMP_BITS'(1) >= k_ext);
        ctrl0.col_last = (c_ext == n_eff - CMP_BITS'(1));
        ctrl0.row_last = (r_ext == n_eff - CMP_BITS'(1));
        ctrl0.top_row  = POS_BITS'(r_ext + CMP_BITS'(1) - k_ext);
        ctrl0.left_col = POS_BITS'(c_ext + CMP_BITS'(1) - k_ext);
    end

    // store row k back in the same column leaves the strip; strip ram reads
    // the old strip of this column and the strip k columns back
    assign store_wr_addr   = {row_reg, col_reg};
    assign store_rd_addr   = {IDX_BITS'(r_ext - k_ext), col_reg};
    assign strip_rd_a_addr = col_reg;
    assign strip_rd_b_addr = IDX_BITS'(c_ext - k_ext);

    // config writes and raster advance: wrap at the end of the matrix, restart on a config write
    always_comb begin
        matrix_size_next = matrix_size_reg;
        window_size_next = window_size_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MATRIX_SIZE: matrix_size_next = cfg_wdata;
                REG_WINDOW_SIZE: window_size_next = cfg_wdata;
                default:         matrix_size_next = matrix_size_reg;
            endcase
            row_next = '0;
            col_next = '0;
        end else if (s_accept) begin
            if (!ctrl0.col_last) begin
                col_next = col_reg + IDX_BITS'(1);
            end else if (!ctrl0.row_last) begin
                col_next = '0;
                row_next = row_reg + IDX_BITS'(1);
            end else begin
                col_next = '0;
                row_next = '0;
            end
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (adv) begin
            v1_next = s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= MATRIX_SIZE_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
            row_reg         <= '0;
            col_reg         <= '0;
            v1_reg          <= 1'b0;
        end else begin
            matrix_size_reg <= matrix_size_next;
            window_size_reg <= window_size_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            v1_reg          <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ctrl1_reg <= ctrl0;
            col1_reg  <= col_reg;
            elem1_reg <= DATA_BITS'(s_tdata);
        end
    end

    sws_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_element_store (
        .aclk    (aclk),
        .we      (s_accept),
        .wr_addr (store_wr_addr),
        .wr_data (DATA_BITS'(s_tdata)),
        .rd_en   (s_accept),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data)
    );

    sws_ram #(
        .WIDTH (STRIP_BITS),
        .DEPTH (1 << IDX_BITS)
    ) u_strip_near (
        .aclk    (aclk),
        .we      (strip_we),
        .wr_addr (strip_wr_addr),
        .wr_data (strip_new),
        .rd_en   (s_accept),
        .rd_addr (strip_rd_a_addr),
        .rd_data (strip_rd_a_data)
    );

    sws_ram #(
        .WIDTH (STRIP_BITS),
        .DEPTH (1 << IDX_BITS)
    ) u_strip_far (
        .aclk    (aclk),
        .we      (strip_we),
        .wr_addr (strip_wr_addr),
        .wr_data (strip_new),
        .rd_en   (s_accept),
        .rd_addr (strip_rd_b_addr),
        .rd_data (strip_rd_b_data)
    );

    // ---------------------------------------------------------------
    // sum stage: update the column strip, then the running row sum
    // ---------------------------------------------------------------
    always_comb begin
        // row 0 starts every strip from zero, so stale ram contents never show
        old_strip = ctrl1_reg.row_zero ? '0 : $signed(strip_rd_a_data);
        drop_elem = ctrl1_reg.row_ge_k ? STRIP_BITS'($signed(store_rd_data)) : '0;
        strip_new = old_strip + STRIP_BITS'(elem1_reg) - drop_elem;

        // with a window of one the strip one column back was written on the
        // same edge as this read, so take it from the last computed strip
        far_strip = k_one ? last_strip_reg : $signed(strip_rd_b_data);
        row_base  = ctrl1_reg.col_zero ? '0 : row_sum_reg;
        row_drop  = ctrl1_reg.col_ge_k ? SUM_BITS'(far_strip) : '0;

        row_sum_next    = row_sum_reg;
        last_strip_next = last_strip_reg;
        if (s1_fire) begin
            last_strip_next = strip_new;
            if (k_valid && ctrl1_reg.row_full) begin
                row_sum_next = row_base + SUM_BITS'(strip_new) - row_drop;
            end
        end

        produce = k_valid && ctrl1_reg.row_full && ctrl1_reg.col_full;
    end

    assign strip_we      = s1_fire && k_valid;
    assign strip_wr_addr = col1_reg;

    always_ff @(posedge aclk) begin
        row_sum_reg    <= row_sum_next;
        last_strip_reg <= last_strip_next;
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = s1_fire && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && produce) begin
            m_data_reg <= OUT_TDATA_BITS'({ctrl1_reg.left_col, ctrl1_reg.top_row,
                                           row_sum_next});
            m_user_reg <= ctrl1_reg.col_last;
            m_last_reg <= ctrl1_reg.col_last && ctrl1_reg.row_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the far strip read must not meet the strip write unless it is forwarded
    `SWS_ASSERT_SAME(a_strip_far_no_collision,
        strip_we && s_accept && ctrl0.col_ge_k && !k_one,
        strip_wr_addr != strip_rd_b_addr,
        "far strip read collides with strip write")

    // the raster column stays inside the matrix
    `SWS_ASSERT_SAME(a_col_in_range, 1'b1, c_ext < n_eff,
        "column position beyond matrix size")

    // the last window of the matrix is also the last of its row
    `SWS_ASSERT_SAME(a_matrix_end_row_end, m_valid_reg && m_last_reg, m_user_reg,
        "matrix end without row end")

    // a stalled sum stage keeps its beat
    `SWS_ASSERT_NEXT(a_s1_hold, v1_reg && !adv, v1_reg && $stable(col1_reg),
        "sum stage lost its beat under stall")

endmodule

`default_nettype wire

/* rtl/sws_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module sws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        // read returns the contents before a same-edge write
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
